[rtl/skt_pkg.sv]
// ============================================================================
// skt_pkg: shared types and codes for the sorted key table
// Operation and status codes, default sizes, and the per-cell control struct.
// ============================================================================
package skt_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Broadcast to every cell during the update cycle
    typedef struct packed {
        logic do_insert;
        logic do_delete;
    } cell_ctl_t;

endpackage

[rtl/sorted_key_table_unit.sv]
// The input beat is registered when taken; the cell row then registers its parallel
// compare flags in the compare phase, and the result is registered in the shift/update
//   phase. A new item can be taken during the update phase of the previous one.
// A waiting result blocks the next input beat only while an update also waits; an
//   update waits only while the output register still holds an untaken result.
// Reset clears the entry count and the control state; cell keys are not reset.
// ============================================================================
// sorted_key_table_unit: ascending table of unique signed keys
// Insert, delete and search on a row of compare-and-shift cells.
// ============================================================================
module sorted_key_table_unit #(
    parameter int  DEPTH    = skt_pkg::DEPTH_DEF,
    parameter int  KEY_BITS = skt_pkg::KEY_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [skt_pkg::KIND_W-1:0]    kind,
    input  logic signed [KEY_BITS-1:0]    key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [skt_pkg::STATUS_W-1:0]  status,
    output logic [CNT_W-1:0]              index,
    output logic [CNT_W-1:0]              count
);
    import skt_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMP  = 2'd1;
    localparam logic [1:0] PH_UPD  = 2'd2;

    logic [1:0]                 phase_reg;
    logic [1:0]                 phase_next;
    logic [KIND_W-1:0]          kind_reg;
    logic signed [KEY_BITS-1:0] item_key_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [STATUS_W-1:0]        status_reg;
    logic [CNT_W-1:0]           index_reg;
    logic [CNT_W-1:0]           count_out_reg;

    logic                       in_accept;
    logic                       out_blocked;
    logic                       upd_fire;
    logic                       cmp_en;
    cell_ctl_t                  ctl;
    cell_ctl_t                  ctl_sel;
    logic [STATUS_W-1:0]        status_sel;
    logic [CNT_W-1:0]           index_sel;
    logic [CNT_W-1:0]           count_sel;

    logic signed [KEY_BITS-1:0] cell_key_w [DEPTH];
    logic [DEPTH-1:0]           lt_w;
    logic [DEPTH-1:0]           eq_w;
    logic [DEPTH-1:0]           boundary;
    logic [CNT_W-1:0]           pos;
    logic                       hit;
    logic                       full;

    assign out_blocked = out_valid_reg && out_stall;
    assign upd_fire    = (phase_reg == PH_UPD) && !out_blocked;
    assign in_stall    = (phase_reg == PH_CMP) || ((phase_reg == PH_UPD) && out_blocked);
    assign in_accept   = in_valid && !in_stall;
    assign cmp_en      = (phase_reg == PH_CMP);

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [KEY_BITS-1:0] left_key;
        logic                       left_lt;
        logic signed [KEY_BITS-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_key = item_key_reg;
            assign left_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign left_key = cell_key_w[i-1];
            assign left_lt  = lt_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_key = cell_key_w[i];
        end
        else
        begin : g_inner
            assign right_key = cell_key_w[i+1];
        end

        assign boundary[i] = !lt_w[i] && left_lt;

        skt_cell #(
            .KEY_BITS (KEY_BITS),
            .CNT_W    (CNT_W),
            .INDEX    (i)
        ) u_cell (
            .clk       (clk),
            .key       (item_key_reg),
            .count     (count_reg),
            .cmp_en    (cmp_en),
            .ctl       (ctl),
            .left_key  (left_key),
            .left_lt   (left_lt),
            .right_key (right_key),
            .cell_key  (cell_key_w[i]),
            .lt        (lt_w[i]),
            .eq        (eq_w[i])
        );
    end

    // ------------------------------------------------------------------
    // Resolve position and decide the operation
    // ------------------------------------------------------------------
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            pos = pos | ({CNT_W{boundary[i]}} & CNT_W'(i));
        end
        // every stored key is below: position is one past the end
        if (lt_w[DEPTH-1])
        begin
            pos = CNT_W'(DEPTH);
        end
    end

    assign hit  = |eq_w;
    assign full = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        ctl_sel    = '0;
        status_sel = ST_MISSING;
        index_sel  = '0;
        count_sel  = count_reg;
        unique case (kind_reg)
            KIND_INSERT:
            begin
                index_sel = pos;
                if (hit)
                begin
                    status_sel = ST_DUP;
                end
                else if (full)
                begin
                    status_sel = ST_FULL;
                end
                else
                begin
                    status_sel        = ST_DONE;
                    ctl_sel.do_insert = 1'b1;
                    count_sel         = count_reg + 1'b1;
                end
            end
            KIND_DELETE:
            begin
                if (hit)
                begin
                    status_sel        = ST_DONE;
                    index_sel         = pos;
                    ctl_sel.do_delete = 1'b1;
                    count_sel         = count_reg - 1'b1;
                end
            end
            default:
            begin
                // search, and the unused code decoded as search
                if (hit)
                begin
                    status_sel = ST_DONE;
                    index_sel  = pos;
                end
            end
        endcase
    end

    assign ctl        = upd_fire ? ctl_sel : '0;
    assign count_next = upd_fire ? count_sel : count_reg;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (in_accept) phase_next = PH_CMP;
            PH_CMP:  phase_next = PH_UPD;
            PH_UPD:
            begin
                if (upd_fire)
                begin
                    phase_next = in_accept ? PH_CMP : PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    assign out_valid_next = upd_fire || out_blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg     <= kind;
            item_key_reg <= key;
        end
        if (upd_fire)
        begin
            status_reg    <= status_sel;
            index_reg     <= index_sel;
            count_out_reg <= count_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;
    assign count     = count_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds table depth");

    a_lt_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_UPD) |-> (((lt_w >> 1) & ~lt_w) == '0))
        else $error("below-key flags not a prefix: table out of order");

    a_eq_single: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_UPD) |-> $onehot0(eq_w))
        else $error("key matches more than one cell");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_insert |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not advance entry count");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_delete |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("delete did not drop entry count");

endmodule

[rtl/skt_cell.sv]
// ============================================================================
// skt_cell: one slot of the sorted key table
// Holds one key, compares it with the broadcast key, and takes a key from its
// left or right neighbor when an insert or delete opens or closes a gap.
// ============================================================================
module skt_cell #(
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF,
    parameter int CNT_W    = 5,
    parameter int INDEX    = 0
) (
    input  logic                       clk,
    input  logic signed [KEY_BITS-1:0] key,
    input  logic        [CNT_W-1:0]    count,
    input  logic                       cmp_en,
    input  skt_pkg::cell_ctl_t         ctl,
    input  logic signed [KEY_BITS-1:0] left_key,
    input  logic                       left_lt,
    input  logic signed [KEY_BITS-1:0] right_key,
    output logic signed [KEY_BITS-1:0] cell_key,
    output logic                       lt,
    output logic                       eq
);
    import skt_pkg::*;

    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_next;
    logic                       lt_reg;
    logic                       eq_reg;
    logic                       valid;

    assign valid = count > CNT_W'(INDEX);

    always_comb
    begin
        priority if (ctl.do_insert && !lt_reg)
        begin
            // first cell at or past the insert point takes the new key
            key_next = left_lt ? key : left_key;
        end
        else if (ctl.do_delete && !lt_reg)
        begin
            key_next = right_key;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (cmp_en)
        begin
            lt_reg <= valid && (key_reg < key);
            eq_reg <= valid && (key_reg == key);
        end
    end

    assign cell_key = key_reg;
    assign lt       = lt_reg;
    assign eq       = eq_reg;

endmodule
